### hdl/padt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and interface types of the peer address demux table.
// No dependencies.
package padt_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int NUM_SESSIONS_DEF  = 64;
    localparam int DEFAULT_QUOTA_DEF = 16;

    localparam int OP_W   = 3;
    localparam int FAM_W  = 2;
    localparam int IP_W   = 64;
    localparam int PORT_W = 16;
    localparam int SESS_W = 6;
    localparam int ST_W   = 2;
    localparam int OUT_W  = 9;

    localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_EXACT  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_IP     = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_SESS   = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd5;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED   = 3'd7;

    localparam logic [FAM_W-1:0] FAM_ANY     = 2'd0;
    localparam logic [FAM_W-1:0] FAM_IPV4    = 2'd1;
    localparam logic [FAM_W-1:0] FAM_IPV6    = 2'd2;
    localparam logic [FAM_W-1:0] FAM_INVALID = 2'd3;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_CONFLICT = 2'd1;
    localparam logic [ST_W-1:0] ST_LIMIT    = 2'd2;

    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_scan;
        logic last_issue;
        logic out_free;
    } t_dp_stat;

endpackage

### hdl/padt_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the peer address demux table: load, count read, table scan, finish.
// Depends on padt_pkg.
module padt_ctrl import padt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WAIT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.issue  = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = i_stat.need_scan ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free) else $error("finish while output full");
    a_scan_from_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_cmd.issue) |-> $past(r_state) == S_WAIT) else $error("scan without count read");
    a_load_then_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_WAIT) else $error("load not followed by wait");

endmodule

### hdl/padt_datapath.sv
`timescale 1ns / 1ps
// Datapath of the peer address demux table: item registers, entry memory, valid bits,
// session count memory, scan compare stage and output register. Depends on padt_pkg.
module padt_datapath import padt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NUM_SESSIONS  = NUM_SESSIONS_DEF,
    parameter int DEFAULT_QUOTA = DEFAULT_QUOTA_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl_cmd          i_cmd,
    output t_dp_stat          o_stat,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [FAM_W-1:0]  i_family,
    input  logic [IP_W-1:0]   i_ip_high,
    input  logic [IP_W-1:0]   i_ip_low,
    input  logic [PORT_W-1:0] i_port,
    input  logic [SESS_W-1:0] i_session,
    input  logic              i_cfg_wr_en,
    input  logic [OUT_W-1:0]  i_cfg_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic              o_found,
    output logic [SESS_W-1:0] o_owner_session,
    output logic [OUT_W-1:0]  o_removed_count,
    output logic [OUT_W-1:0]  o_total_entries,
    output logic [OUT_W-1:0]  o_session_entries
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SD = (NUM_SESSIONS < 64) ? NUM_SESSIONS : 64;
    localparam int SW = $clog2(SD);
    localparam int QW = ($clog2(DEFAULT_QUOTA + 1) > OUT_W) ? $clog2(DEFAULT_QUOTA + 1) : OUT_W;
    localparam int XW = (QW > CW) ? QW : CW;

    typedef struct packed {
        logic              is6;
        logic [IP_W-1:0]   hi;
        logic [IP_W-1:0]   lo;
        logic [PORT_W-1:0] port;
        logic [SESS_W-1:0] owner;
    } t_entry;

    // Item and configuration registers.
    logic [OP_W-1:0]   r_op;
    logic [FAM_W-1:0]  r_fam;
    logic [IP_W-1:0]   r_hi;
    logic [IP_W-1:0]   r_lo;
    logic [PORT_W-1:0] r_port;
    logic [SESS_W-1:0] r_sess;
    logic [OUT_W-1:0]  r_cfg;

    // Table storage.
    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rec;
    logic   r_ev [TABLE_ENTRIES];
    logic [CW-1:0] r_cmem [SD];
    logic          r_cv [SD];
    logic [CW-1:0] r_cnt_rd;
    logic          r_cnt_ok;
    logic [CW-1:0] r_total;

    // Scan pipeline and results gathered over the scan.
    logic [IW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_cmp_ev;
    logic              r_hit;
    logic [SESS_W-1:0] r_hit_own;
    logic              r_slot_f;
    logic [IW-1:0]     r_slot;
    logic              r_fnd;
    logic [SESS_W-1:0] r_fnd_own;
    logic [CW-1:0]     r_rem;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic              r_found;
    logic [SESS_W-1:0] r_owner;
    logic [OUT_W-1:0]  r_removed;
    logic [OUT_W-1:0]  r_tot_out;
    logic [OUT_W-1:0]  r_sess_out;

    logic          key_ok, v6, sess_ok;
    logic [SW-1:0] sidx;
    logic          m_addr, m_port, m_own, m_fam, drop;
    logic [CW-1:0] cnt_cur;
    logic [QW-1:0] limit;
    logic          at_limit, do_ins;
    logic          need_scan;
    logic [ST_W-1:0] n_status;
    logic [CW-1:0] n_cnt, n_total, n_removed;
    t_entry        n_rec;

    assign key_ok  = (r_fam == FAM_IPV4) || (r_fam == FAM_IPV6);
    assign v6      = (r_fam == FAM_IPV6);
    assign sess_ok = (32'(r_sess) < NUM_SESSIONS);
    assign sidx    = r_sess[SW-1:0];

    always_comb begin
        need_scan = 1'b0;
        case (r_op)
            OP_REGISTER, OP_LOOKUP:  need_scan = key_ok;
            OP_REM_EXACT, OP_REM_IP: need_scan = key_ok && sess_ok;
            OP_REM_SESS:             need_scan = sess_ok;
            default:                 need_scan = 1'b0;
        endcase
    end
    assign o_stat.need_scan  = need_scan;
    assign o_stat.last_issue = (r_idx == IW'(TABLE_ENTRIES - 1));
    assign o_stat.out_free   = !r_out_valid || !i_stall;

    // Compare stage on the entry read in the previous cycle.
    assign m_addr = (r_rec.is6 == v6) && (r_rec.hi == r_hi) && (r_rec.lo == r_lo);
    assign m_port = (r_rec.port == r_port);
    assign m_own  = (r_rec.owner == r_sess);
    assign m_fam  = (r_fam == FAM_ANY) || ((r_fam == FAM_IPV4) && !r_rec.is6) ||
                    ((r_fam == FAM_IPV6) && r_rec.is6);

    always_comb begin
        drop = 1'b0;
        if (r_cmp_vld && r_cmp_ev && m_own) begin
            case (r_op)
                OP_REM_EXACT: drop = m_addr && m_port && (r_rem == '0);
                OP_REM_IP:    drop = m_addr;
                OP_REM_SESS:  drop = m_fam;
                default:      drop = 1'b0;
            endcase
        end
    end

    // Result of the item once the scan is done.
    assign cnt_cur  = r_cnt_ok ? r_cnt_rd : '0;
    assign limit    = (r_cfg == '0) ? QW'(DEFAULT_QUOTA) : QW'(r_cfg);
    assign at_limit = (XW'(cnt_cur) >= XW'(limit));

    always_comb begin
        n_status  = ST_OK;
        do_ins    = 1'b0;
        n_cnt     = cnt_cur;
        n_total   = r_total;
        n_removed = '0;
        case (r_op)
            OP_REGISTER: begin
                if (!key_ok) begin
                    n_status = ST_CONFLICT;
                end else if (r_hit) begin
                    n_status = (r_hit_own == r_sess) ? ST_OK : ST_CONFLICT;
                end else if (!sess_ok || at_limit) begin
                    n_status = ST_LIMIT;
                end else if (!r_slot_f) begin
                    n_status = ST_CONFLICT;
                end else begin
                    do_ins  = 1'b1;
                    n_cnt   = cnt_cur + CW'(1);
                    n_total = r_total + CW'(1);
                end
            end
            OP_REM_EXACT, OP_REM_IP, OP_REM_SESS: begin
                n_removed = r_rem;
                n_cnt     = cnt_cur - r_rem;
                n_total   = r_total - r_rem;
            end
            OP_CLEAR: begin
                n_removed = r_total;
                n_cnt     = '0;
                n_total   = '0;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign n_rec.is6   = v6;
    assign n_rec.hi    = r_hi;
    assign n_rec.lo    = r_lo;
    assign n_rec.port  = r_port;
    assign n_rec.owner = r_sess;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_fam  <= i_family;
            r_hi   <= (i_family == FAM_IPV6) ? i_ip_high : '0;
            r_lo   <= (i_family == FAM_IPV6) ? i_ip_low : {32'd0, i_ip_low[31:0]};
            r_port <= i_port;
            r_sess <= i_session;
        end
        if (i_cmd.finish && do_ins) begin
            r_mem[r_slot] <= n_rec;
        end
        r_rec    <= r_mem[r_idx];
        r_cmp_ev <= r_ev[r_idx];
        r_cmp_idx <= r_idx;
        if (i_cmd.finish && sess_ok && (r_op != OP_CLEAR)) begin
            r_cmem[sidx] <= n_cnt;
        end
        r_cnt_rd <= r_cmem[sidx];
        r_cnt_ok <= r_cv[sidx];
        if (i_cmd.finish) begin
            r_status   <= n_status;
            r_found    <= (r_op == OP_LOOKUP) && key_ok && r_fnd;
            r_owner    <= ((r_op == OP_LOOKUP) && key_ok && r_fnd) ? r_fnd_own : '0;
            r_removed  <= OUT_W'(n_removed);
            r_tot_out  <= OUT_W'(n_total);
            r_sess_out <= sess_ok ? OUT_W'(n_cnt) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_hit_own   <= '0;
            r_slot_f    <= 1'b0;
            r_slot      <= '0;
            r_fnd       <= 1'b0;
            r_fnd_own   <= '0;
            r_rem       <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_ev[i] <= 1'b0;
            end
            for (int s = 0; s < SD; s++) begin
                r_cv[s] <= 1'b0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_idx    <= '0;
                r_hit    <= 1'b0;
                r_slot_f <= 1'b0;
                r_fnd    <= 1'b0;
                r_rem    <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + IW'(1);
            end
            if (r_cmp_vld) begin
                if (r_cmp_ev) begin
                    if (!r_hit && m_addr && m_port) begin
                        r_hit     <= 1'b1;
                        r_hit_own <= r_rec.owner;
                    end
                    if (!r_fnd && m_addr && m_port) begin
                        r_fnd     <= 1'b1;
                        r_fnd_own <= r_rec.owner;
                    end
                end else if (!r_slot_f) begin
                    r_slot_f <= 1'b1;
                    r_slot   <= r_cmp_idx;
                end
            end
            if (drop) begin
                r_ev[r_cmp_idx] <= 1'b0;
                r_rem           <= r_rem + CW'(1);
            end
            if (i_cmd.finish) begin
                r_total <= n_total;
                if (r_op == OP_CLEAR) begin
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        r_ev[i] <= 1'b0;
                    end
                    for (int s = 0; s < SD; s++) begin
                        r_cv[s] <= 1'b0;
                    end
                end else begin
                    if (do_ins) begin
                        r_ev[r_slot] <= 1'b1;
                    end
                    if (sess_ok) begin
                        r_cv[sidx] <= 1'b1;
                    end
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_found           = r_found;
    assign o_owner_session   = r_owner;
    assign o_removed_count   = r_removed;
    assign o_total_entries   = r_tot_out;
    assign o_session_entries = r_sess_out;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) <= TABLE_ENTRIES) else $error("entry count above table size");
    a_drop_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drop |-> (r_op == OP_REM_EXACT || r_op == OP_REM_IP || r_op == OP_REM_SESS))
        else $error("entry removed by a non-removal item");
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_op == OP_CLEAR) |=> r_total == '0) else $error("clear left entries");
    a_insert_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && do_ins) |-> r_slot_f && !r_hit) else $error("insert without free slot");

endmodule

### hdl/peer_address_demux_table.sv
`timescale 1ns / 1ps
// Top level of the peer address demux table: sequencer and datapath.
// Depends on padt_pkg, padt_ctrl and padt_datapath.
//
//  Channel  Handshake           Payload
//  input    i_valid / o_stall   i_operation, i_family, i_ip_high, i_ip_low, i_port, i_session
//  output   o_valid / i_stall   o_status, o_found, o_owner_session, o_removed_count,
//                               o_total_entries, o_session_entries
//  config   i_cfg_wr_en         i_cfg_wr_data
//
// Register, lookup and removal items run a scan of the table that reads one entry of the
// entry memory per cycle. Query, clear and items that need no scan go from the count read
// straight to finish. One item is in work at a time; the output register holds a finished item
// while the next one is accepted. Reset empties the table at once through per-entry valid bits.
module peer_address_demux_table import padt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NUM_SESSIONS  = NUM_SESSIONS_DEF,
    parameter int DEFAULT_QUOTA = DEFAULT_QUOTA_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [FAM_W-1:0]  i_family,
    input  logic [IP_W-1:0]   i_ip_high,
    input  logic [IP_W-1:0]   i_ip_low,
    input  logic [PORT_W-1:0] i_port,
    input  logic [SESS_W-1:0] i_session,
    input  logic              i_cfg_wr_en,
    input  logic [OUT_W-1:0]  i_cfg_wr_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic              o_found,
    output logic [SESS_W-1:0] o_owner_session,
    output logic [OUT_W-1:0]  o_removed_count,
    output logic [OUT_W-1:0]  o_total_entries,
    output logic [OUT_W-1:0]  o_session_entries
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    padt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    padt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_SESSIONS  (NUM_SESSIONS),
        .DEFAULT_QUOTA (DEFAULT_QUOTA)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_operation       (i_operation),
        .i_family          (i_family),
        .i_ip_high         (i_ip_high),
        .i_ip_low          (i_ip_low),
        .i_port            (i_port),
        .i_session         (i_session),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_found           (o_found),
        .o_owner_session   (o_owner_session),
        .o_removed_count   (o_removed_count),
        .o_total_entries   (o_total_entries),
        .o_session_entries (o_session_entries)
    );

endmodule

### sim/peer_address_demux_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of peer_address_demux_table: directed and random endpoint items
// checked against a predictor of the table. Depends on padt_pkg and the table RTL.
module peer_address_demux_table_test import padt_pkg::*;;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [FAM_W-1:0]  fam;
        logic [IP_W-1:0]   hi;
        logic [IP_W-1:0]   lo;
        logic [PORT_W-1:0] port;
        logic [SESS_W-1:0] sess;
    } t_endpoint_item;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic              found;
        logic [SESS_W-1:0] owner;
        logic [OUT_W-1:0]  removed;
        logic [OUT_W-1:0]  total;
        logic [OUT_W-1:0]  sess_entries;
    } t_table_result;

    localparam int N_ENT  = TABLE_ENTRIES_DEF;
    localparam int N_SESS = NUM_SESSIONS_DEF;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [OP_W-1:0]   i_operation = '0;
    logic [FAM_W-1:0]  i_family = '0;
    logic [IP_W-1:0]   i_ip_high = '0;
    logic [IP_W-1:0]   i_ip_low = '0;
    logic [PORT_W-1:0] i_port = '0;
    logic [SESS_W-1:0] i_session = '0;
    logic              i_cfg_wr_en = 1'b0;
    logic [OUT_W-1:0]  i_cfg_wr_data = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic              o_found;
    logic [SESS_W-1:0] o_owner_session;
    logic [OUT_W-1:0]  o_removed_count;
    logic [OUT_W-1:0]  o_total_entries;
    logic [OUT_W-1:0]  o_session_entries;

    peer_address_demux_table u_dut (.*);

    bit               tbl_valid [N_ENT];
    bit               tbl_v6 [N_ENT];
    logic [IP_W-1:0]  tbl_hi [N_ENT];
    logic [IP_W-1:0]  tbl_lo [N_ENT];
    logic [PORT_W-1:0] tbl_port [N_ENT];
    logic [SESS_W-1:0] tbl_owner [N_ENT];
    int               sess_cnt [N_SESS];
    int               total_cnt;
    int               quota_reg;

    t_endpoint_item   pending [$];
    t_table_result    expected_results [$];
    t_endpoint_item   cur_item;
    int               snd_idle_pct;
    int               rcv_idle_pct;
    int               errors;
    int               items_sent;
    int               limit_refusals;
    int               conflict_refusals;

    logic [IP_W-1:0]   ip_pool_hi [8];
    logic [IP_W-1:0]   ip_pool_lo [8];
    logic [PORT_W-1:0] port_pool [4];
    logic [SESS_W-1:0] sess_pool [8];
    int                cfg_plan [6] = '{0, 1, 256, 2, 0, 17};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Timeout after %0d items.", items_sent);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void drop_entry(int idx);
        tbl_valid[idx] = 1'b0;
        if (sess_cnt[tbl_owner[idx]] > 0) sess_cnt[tbl_owner[idx]]--;
        if (total_cnt > 0) total_cnt--;
    endfunction

    function automatic t_table_result table_apply(t_endpoint_item it);
        t_table_result r;
        logic key_ok;
        logic v6;
        logic fam_match;
        logic [IP_W-1:0] hi;
        logic [IP_W-1:0] lo;
        int lim;
        int hit;
        int slot;
        int removed;
        r = '{default: '0};
        key_ok = (it.fam == FAM_IPV4) || (it.fam == FAM_IPV6);
        v6 = (it.fam == FAM_IPV6);
        hi = v6 ? it.hi : '0;
        lo = v6 ? it.lo : {32'd0, it.lo[31:0]};
        removed = 0;
        case (it.op)
            OP_REGISTER: begin
                lim = (quota_reg != 0) ? quota_reg : DEFAULT_QUOTA_DEF;
                hit = -1;
                slot = -1;
                if (!key_ok) begin
                    r.status = ST_CONFLICT;
                end else begin
                    for (int i = 0; i < N_ENT; i++) begin
                        if (tbl_valid[i]) begin
                            if (hit < 0 && tbl_v6[i] == v6 && tbl_hi[i] == hi && tbl_lo[i] == lo
                                && tbl_port[i] == it.port) hit = i;
                        end else if (slot < 0) begin
                            slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        r.status = (tbl_owner[hit] == it.sess) ? ST_OK : ST_CONFLICT;
                    end else if (sess_cnt[it.sess] >= lim) begin
                        r.status = ST_LIMIT;
                    end else if (slot < 0) begin
                        r.status = ST_CONFLICT;
                    end else begin
                        tbl_valid[slot] = 1'b1;
                        tbl_v6[slot] = v6;
                        tbl_hi[slot] = hi;
                        tbl_lo[slot] = lo;
                        tbl_port[slot] = it.port;
                        tbl_owner[slot] = it.sess;
                        sess_cnt[it.sess]++;
                        total_cnt++;
                    end
                end
            end
            OP_LOOKUP: begin
                if (key_ok) begin
                    for (int i = 0; i < N_ENT; i++) begin
                        if (tbl_valid[i] && tbl_v6[i] == v6 && tbl_hi[i] == hi && tbl_lo[i] == lo
                            && tbl_port[i] == it.port) begin
                            r.found = 1'b1;
                            r.owner = tbl_owner[i];
                            break;
                        end
                    end
                end
            end
            OP_REM_EXACT: begin
                if (key_ok) begin
                    for (int i = 0; i < N_ENT; i++) begin
                        if (tbl_valid[i] && tbl_owner[i] == it.sess && tbl_v6[i] == v6
                            && tbl_hi[i] == hi && tbl_lo[i] == lo && tbl_port[i] == it.port) begin
                            drop_entry(i);
                            removed = 1;
                            break;
                        end
                    end
                end
            end
            OP_REM_IP: begin
                if (key_ok) begin
                    for (int i = 0; i < N_ENT; i++) begin
                        if (tbl_valid[i] && tbl_owner[i] == it.sess && tbl_v6[i] == v6
                            && tbl_hi[i] == hi && tbl_lo[i] == lo) begin
                            drop_entry(i);
                            removed++;
                        end
                    end
                end
            end
            OP_REM_SESS: begin
                for (int i = 0; i < N_ENT; i++) begin
                    fam_match = (it.fam == FAM_ANY) || (it.fam == FAM_IPV4 && !tbl_v6[i])
                        || (it.fam == FAM_IPV6 && tbl_v6[i]);
                    if (tbl_valid[i] && tbl_owner[i] == it.sess && fam_match) begin
                        drop_entry(i);
                        removed++;
                    end
                end
            end
            OP_CLEAR: begin
                removed = total_cnt;
                for (int i = 0; i < N_ENT; i++) tbl_valid[i] = 1'b0;
                for (int i = 0; i < N_SESS; i++) sess_cnt[i] = 0;
                total_cnt = 0;
            end
            default: begin
            end
        endcase
        r.removed = removed[OUT_W-1:0];
        r.total = total_cnt[OUT_W-1:0];
        r.sess_entries = sess_cnt[it.sess][OUT_W-1:0];
        return r;
    endfunction

    function automatic t_endpoint_item mk(logic [OP_W-1:0] op, logic [FAM_W-1:0] fam,
                                          logic [IP_W-1:0] hi, logic [IP_W-1:0] lo,
                                          logic [PORT_W-1:0] port, logic [SESS_W-1:0] sess);
        t_endpoint_item it;
        it.op = op;
        it.fam = fam;
        it.hi = hi;
        it.lo = lo;
        it.port = port;
        it.sess = sess;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Most items reuse a small set of addresses, ports and sessions so that hits, owner
    // conflicts and quota refusals are frequent; the rest are fully random noise.
    function automatic t_endpoint_item rand_item();
        t_endpoint_item it;
        int pick;
        int ip_sel;
        pick = $urandom_range(99);
        if (pick < 38) it.op = OP_REGISTER;
        else if (pick < 58) it.op = OP_LOOKUP;
        else if (pick < 71) it.op = OP_REM_EXACT;
        else if (pick < 80) it.op = OP_REM_IP;
        else if (pick < 87) it.op = OP_REM_SESS;
        else if (pick < 96) it.op = OP_QUERY;
        else if (pick < 98) it.op = OP_CLEAR;
        else it.op = OP_RESERVED;
        ip_sel = $urandom_range(7);
        if ($urandom_range(99) < 85) begin
            it.fam = ip_sel[0] ? FAM_IPV6 : FAM_IPV4;
            it.hi = ip_pool_hi[ip_sel];
            it.lo = ip_pool_lo[ip_sel];
            it.port = port_pool[$urandom_range(3)];
        end else begin
            it.fam = FAM_W'($urandom_range(3));
            it.hi = rand64();
            it.lo = rand64();
            it.port = PORT_W'($urandom());
        end
        // Half of the non-IPv6 items carry random upper address bits that the block must ignore.
        if (it.fam != FAM_IPV6 && $urandom_range(1)) begin
            it.hi = rand64();
            it.lo[63:32] = $urandom();
        end
        if (it.op == OP_REM_SESS && $urandom_range(3) == 0) it.fam = FAM_W'($urandom_range(3));
        it.sess = ($urandom_range(99) < 85) ? sess_pool[$urandom_range(7)] : SESS_W'($urandom());
        return it;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_table_result r;
        t_endpoint_item nx;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r = table_apply(cur_item);
                expected_results.push_back(r);
                items_sent++;
                if (cur_item.op == OP_REGISTER && r.status == ST_LIMIT) limit_refusals++;
                if (cur_item.op == OP_REGISTER && r.status == ST_CONFLICT) conflict_refusals++;
            end
            if (!i_valid || !o_stall) begin
                if (pending.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    nx = pending.pop_front();
                    cur_item = nx;
                    i_operation <= nx.op;
                    i_family <= nx.fam;
                    i_ip_high <= nx.hi;
                    i_ip_low <= nx.lo;
                    i_port <= nx.port;
                    i_session <= nx.sess;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_table_result e;
        i_stall <= ($urandom_range(99) < rcv_idle_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual status %0d total %0d",
                         $time, o_status, o_total_entries);
                errors++;
            end else begin
                e = expected_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("found", e.found, o_found);
                check_field("owner_session", e.owner, o_owner_session);
                check_field("removed_count", e.removed, o_removed_count);
                check_field("total_entries", e.total, o_total_entries);
                check_field("session_entries", e.sess_entries, o_session_entries);
            end
        end
    end

    task automatic wait_idle();
        while (pending.size() > 0 || i_valid || expected_results.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_quota(int value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value[OUT_W-1:0];
        quota_reg = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [IP_W-1:0] a4;
        logic [IP_W-1:0] a6;
        errors = 0;
        items_sent = 0;
        limit_refusals = 0;
        conflict_refusals = 0;
        total_cnt = 0;
        quota_reg = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        for (int i = 0; i < N_ENT; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < N_SESS; i++) sess_cnt[i] = 0;
        for (int i = 0; i < 8; i++) begin
            ip_pool_hi[i] = rand64();
            ip_pool_lo[i] = rand64();
            sess_pool[i] = (i == 0) ? 6'd0 : (i == 1) ? 6'd63 : 6'($urandom());
        end
        for (int i = 0; i < 4; i++) port_pool[i] = PORT_W'($urandom());
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            snd_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 53 : 0;
            rcv_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 13 : 0;
            if (ph > 0) wait_idle();
            write_quota(cfg_plan[ph]);
            if (ph == 0) begin
                a4 = 64'h0000_0000_c0a8_0001;
                a6 = 64'h2001_0db8_0000_0001;
                pending.push_back(mk(OP_QUERY, FAM_IPV4, '0, '0, '0, 6'd0));
                pending.push_back(mk(OP_REGISTER, FAM_IPV4, '0, a4, 16'd5000, 6'd1));
                pending.push_back(mk(OP_REGISTER, FAM_IPV4, '0, a4, 16'd5000, 6'd1));
                pending.push_back(mk(OP_REGISTER, FAM_IPV4, '0, a4, 16'd5000, 6'd2));
                pending.push_back(mk(OP_LOOKUP, FAM_IPV4, '1, {32'hdead_beef, a4[31:0]},
                                     16'd5000, 6'd9));
                pending.push_back(mk(OP_REGISTER, FAM_ANY, '0, a4, 16'd7, 6'd1));
                pending.push_back(mk(OP_REGISTER, FAM_INVALID, '0, a4, 16'd7, 6'd1));
                pending.push_back(mk(OP_LOOKUP, FAM_ANY, '0, a4, 16'd5000, 6'd1));
                pending.push_back(mk(OP_REGISTER, FAM_IPV6, '1, '1, '1, 6'd63));
                pending.push_back(mk(OP_REGISTER, FAM_IPV6, '0, '0, '0, 6'd0));
                pending.push_back(mk(OP_REGISTER, FAM_IPV4, '0, a4, 16'd5001, 6'd1));
                pending.push_back(mk(OP_REM_EXACT, FAM_IPV4, '0, a4, 16'd5000, 6'd2));
                pending.push_back(mk(OP_REM_IP, FAM_IPV4, '0, a4, 16'd0, 6'd1));
                pending.push_back(mk(OP_REGISTER, FAM_IPV4, '0, a4, 16'd5000, 6'd1));
                pending.push_back(mk(OP_REGISTER, FAM_IPV6, a6, a4, 16'd80, 6'd1));
                pending.push_back(mk(OP_REM_SESS, FAM_INVALID, '0, '0, '0, 6'd1));
                pending.push_back(mk(OP_REM_SESS, FAM_IPV4, '0, '0, '0, 6'd1));
                pending.push_back(mk(OP_REM_SESS, FAM_IPV6, '0, '0, '0, 6'd1));
                pending.push_back(mk(OP_REM_EXACT, FAM_INVALID, '1, '1, '1, 6'd63));
                pending.push_back(mk(OP_REM_SESS, FAM_ANY, '0, '0, '0, 6'd63));
                pending.push_back(mk(OP_RESERVED, FAM_IPV6, '1, '1, '1, 6'd0));
                pending.push_back(mk(OP_LOOKUP, FAM_IPV6, '1, '1, '1, 6'd0));
                pending.push_back(mk(OP_CLEAR, FAM_ANY, '0, '0, '0, 6'd0));
                pending.push_back(mk(OP_QUERY, FAM_ANY, '0, '0, '0, 6'd0));
            end
            // With the largest quota the table is filled until new endpoints are refused.
            if (cfg_plan[ph] == 256) begin
                for (int i = 0; i < 260; i++) begin
                    pending.push_back(mk(OP_REGISTER, FAM_IPV6, rand64(), rand64(),
                                         PORT_W'($urandom()), sess_pool[$urandom_range(7)]));
                end
            end
            for (int i = 0; i < 265; i++) pending.push_back(rand_item());
        end

        wait_idle();
        $display("Ran %0d items over %0d quota settings and three idle patterns.",
                 items_sent, 6);
        $display("Registers refused: %0d at quota, %0d as conflict or full table.",
                 limit_refusals, conflict_refusals);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/padt_pkg.sv
hdl/padt_ctrl.sv
hdl/padt_datapath.sv
hdl/peer_address_demux_table.sv
sim/peer_address_demux_table_test.sv
